>>> design/rks_pkg.sv
`default_nettype none

package rks_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_WIDTH_DEF   = 32;

  localparam int AREA_W     = 32;
  localparam int POP_W      = 32;
  localparam int TAG_W      = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [POP_W-1:0]  pop;
    logic [TAG_W-1:0]  tag;
  } rec_t;

  typedef struct packed {
    cell_op_t op;
    logic     parity;
    logic     key_sel;
    logic     desc;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/rks_cell.sv
`default_nettype none

module rks_cell #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 7,
  parameter int KEY_WIDTH = rks_pkg::KEY_WIDTH_DEF
) (
  input  wire                    clk,
  input  rks_pkg::cell_ctl_t     ctl,
  input  wire  [CNT_W-1:0]       count,
  input  rks_pkg::rec_t          in_rec,
  input  rks_pkg::rec_t          up_rec,
  input  rks_pkg::rec_t          low_rec,
  input  wire                    low_gt,
  output rks_pkg::rec_t          rec,
  output logic                   gt
);
  import rks_pkg::*;

  localparam int CMP_W = (KEY_WIDTH < AREA_W) ? KEY_WIDTH : AREA_W;
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);
  localparam logic IDX_ODD = 1'(IDX % 2);
  localparam logic HAS_LOW = (IDX > 0);

  rec_t rec_r, rec_nxt;
  logic [CMP_W-1:0] key_self, key_up, cmp_a, cmp_b;
  logic lower_act, upper_act;

  // goes after the upper neighbor under the current order
  always_comb begin
    key_self = ctl.key_sel ? rec_r.pop[CMP_W-1:0]  : rec_r.area[CMP_W-1:0];
    key_up   = ctl.key_sel ? up_rec.pop[CMP_W-1:0] : up_rec.area[CMP_W-1:0];
    cmp_a    = ctl.desc ? key_up : key_self;
    cmp_b    = ctl.desc ? key_self : key_up;
    gt       = (cmp_a > cmp_b);
  end

  assign lower_act = (ctl.parity == IDX_ODD) && (count > IDX_P1);
  assign upper_act = HAS_LOW && (ctl.parity != IDX_ODD) && (count > IDX_C);

  always_comb begin
    rec_nxt = rec_r;
    case (ctl.op)
      CELL_LOAD: begin
        if (count == IDX_C) rec_nxt = in_rec;
      end
      CELL_SORT: begin
        if (lower_act && gt) rec_nxt = up_rec;
        else if (upper_act && low_gt) rec_nxt = low_rec;
      end
      CELL_SHIFT: begin
        rec_nxt = up_rec;
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

`default_nettype wire

>>> design/record_key_sorter.sv
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+--------------------
// input    | in_area_value in_population_value in_record_tag    | start & !busy
//          | in_last_record                                     |
// result   | out_area out_population out_tag out_last           | out_valid strobe
// config   | cfg_index cfg_data                                 | cfg_valid & cfg_ready
//
// records load one beat per cycle into a row of cells, one cell per record
// after the last beat, n odd-even transposition passes (one per cycle) sort the row,
// then the results shift out of cell 0; busy is high while sorting and shifting
// the n results appear on consecutive cycles once the sort passes finish
// rst_n is synchronous; cell contents are not reset, the record count is
// the receiver cannot stall; cfg_ready is always high
`default_nettype none

module record_key_sorter #(
  parameter int MAX_RECORDS = rks_pkg::MAX_RECORDS_DEF,
  parameter int KEY_WIDTH   = rks_pkg::KEY_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [rks_pkg::AREA_W-1:0]       in_area_value,
  input  wire  [rks_pkg::POP_W-1:0]        in_population_value,
  input  wire  [rks_pkg::TAG_W-1:0]        in_record_tag,
  input  wire                              in_last_record,
  output logic                             out_valid,
  output logic [rks_pkg::AREA_W-1:0]       out_area,
  output logic [rks_pkg::POP_W-1:0]        out_population,
  output logic [rks_pkg::TAG_W-1:0]        out_tag,
  output logic                             out_last,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [rks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [rks_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rks_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [1:0] {S_LOAD, S_SORT, S_DRAIN} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  pass_r;
  logic              key_sel_r, desc_r;
  logic              out_valid_r, out_last_r;
  rec_t              out_rec_r;

  logic      accept;
  cell_ctl_t ctl;
  rec_t      in_rec;
  rec_t      rec_w [MAX_RECORDS];
  logic      gt_w  [MAX_RECORDS];

  assign accept    = start && (state_r == S_LOAD);
  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = 1'b1;

  assign in_rec.area = in_area_value;
  assign in_rec.pop  = in_population_value;
  assign in_rec.tag  = in_record_tag;

  always_comb begin
    ctl.key_sel = key_sel_r;
    ctl.desc    = desc_r;
    ctl.parity  = pass_r[0];
    case (state_r)
      S_LOAD:  ctl.op = accept ? CELL_LOAD : CELL_HOLD;
      S_SORT:  ctl.op = CELL_SORT;
      S_DRAIN: ctl.op = CELL_SHIFT;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t up_rec, low_rec;
    logic low_gt;
    if (i + 1 < MAX_RECORDS) begin : g_up
      assign up_rec = rec_w[i+1];
    end else begin : g_top
      assign up_rec = '0;
    end
    if (i > 0) begin : g_low
      assign low_rec = rec_w[i-1];
      assign low_gt  = gt_w[i-1];
    end else begin : g_bottom
      assign low_rec = '0;
      assign low_gt  = 1'b0;
    end
    rks_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W),
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count_r),
      .in_rec  (in_rec),
      .up_rec  (up_rec),
      .low_rec (low_rec),
      .low_gt  (low_gt),
      .rec     (rec_w[i]),
      .gt      (gt_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      pass_r      <= '0;
      key_sel_r   <= 1'b0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_SELECT: key_sel_r <= cfg_data[0];
          REG_DESCENDING: desc_r    <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (count_r < MAX_C) count_r <= count_r + ONE_C;
            if (in_last_record) begin
              state_r <= S_SORT;
              pass_r  <= '0;
            end
          end
        end
        S_SORT: begin
          pass_r <= pass_r + ONE_C;
          if (pass_r == count_r - ONE_C) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (count_r == ONE_C);
          count_r     <= count_r - ONE_C;
          if (count_r == ONE_C) state_r <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DRAIN) out_rec_r <= rec_w[0];
  end

  assign out_valid      = out_valid_r;
  assign out_last       = out_last_r;
  assign out_area       = out_rec_r.area;
  assign out_population = out_rec_r.pop;
  assign out_tag        = out_rec_r.tag;

endmodule

`default_nettype wire

>>> design/rks_checker.sv
`default_nettype none

module rks_checker (
  input wire clk,
  input wire rst_n,
  input wire start,
  input wire busy,
  input wire in_last_record,
  input wire out_valid,
  input wire out_last
);

  // a last beat always starts a sort
  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_record |=> busy)
    else $error("busy not raised after last beat");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // results of one batch come on consecutive cycles
  a_drain_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside result burst");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after final beat");

endmodule

bind record_key_sorter rks_checker u_rks_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_record (in_last_record),
  .out_valid      (out_valid),
  .out_last       (out_last)
);

`default_nettype wire
